[hdl/ttb_pkg.sv]
// ttb_pkg: shared types and constants for the triangle tangent/bitangent core
// no dependencies
package ttb_pkg;

   localparam int CoordWidth = 16;
   localparam int ClampWidth = 19;
   localparam int FracShift  = 22;
   // coordinate deltas: 20 bits, products 40, sums 41, shifted numerator 63
   localparam int DeltaWidth = ClampWidth + 1;
   localparam int ProdWidth  = 2 * DeltaWidth;
   localparam int SumWidth   = ProdWidth + 1;
   localparam int NumWidth   = SumWidth + FracShift;
   localparam int DenWidth   = SumWidth;
   localparam int QuotWidth  = 33;

   typedef struct packed {
      logic signed [CoordWidth-1:0] pos_x;
      logic signed [CoordWidth-1:0] pos_y;
      logic signed [CoordWidth-1:0] pos_z;
      logic signed [CoordWidth-1:0] tex_u;
      logic signed [CoordWidth-1:0] tex_v;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] tangent_x;
      logic signed [31:0] tangent_y;
      logic signed [31:0] tangent_z;
      logic signed [31:0] bitangent_x;
      logic signed [31:0] bitangent_y;
      logic signed [31:0] bitangent_z;
      logic               degenerate;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic       load_v0;
      logic       load_v1;
      logic       load_v2;
      logic       calc_delta;
      logic       calc_prod;
      logic       calc_sum;
      logic       div_start;
      logic [2:0] div_sel;
      logic       div_store;
   } ttb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
   } ttb_sts_type;

   // clamp a sign-extended coordinate to the exact datapath range
   function automatic logic signed [ClampWidth-1:0] clamp_coord(
      input logic signed [CoordWidth-1:0] v);
      logic signed [63:0] w;
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      w  = 64'(signed'(v));
      hi = 64'((64'sd1 <<< (ClampWidth - 1)) - 64'sd1);
      lo = -64'(64'sd1 <<< (ClampWidth - 1));
      if (w > hi) w = hi;
      if (w < lo) w = lo;
      return w[ClampWidth-1:0];
   endfunction

endpackage

[hdl/ttb_divider.sv]
// ttb_divider: restoring divider, one quotient bit per cycle, round half away
// depends on ttb_pkg
module ttb_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ttb_pkg::NumWidth-1:0] num,
   input  logic signed [ttb_pkg::DenWidth-1:0] den,
   output logic                               done,
   output logic [31:0]                        quot
);
   import ttb_pkg::*;

   localparam int UW   = NumWidth + 1;           // 2*|n| + |d|
   localparam int CntW = $clog2(UW + 1);

   logic [UW-1:0]      rem_ff, rem_in;           // dividend shifting out
   logic [UW:0]        part_ff, part_in;         // partial remainder
   logic [UW-1:0]      q_ff, q_in;
   logic [DenWidth:0]  dd_ff, dd_in;             // 2*|d|
   logic               neg_ff, neg_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [UW-1:0]      un, ud;
   logic [UW:0]        trial;
   logic [UW-1:0]      qs;
   logic [31:0]        qo;

   // magnitudes of numerator and denominator (the rounding pre-add is applied on start)
   always_comb begin
      un = UW'(num[NumWidth-1] ? -num : num);
      ud = UW'(den[DenWidth-1] ? -den : den);
   end

   always_comb begin
      rem_in  = rem_ff;
      part_in = part_ff;
      q_in    = q_ff;
      dd_in   = dd_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {part_ff[UW-1:0], rem_ff[UW-1]};
      if (start) begin
         rem_in  = (un << 1) + ud;
         part_in = '0;
         q_in    = '0;
         dd_in   = (DenWidth+1)'(ud << 1);
         neg_in  = num[NumWidth-1] ^ den[DenWidth-1];
         cnt_in  = CntW'(UW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_ff << 1;
         if (trial >= (UW+1)'(dd_ff)) begin
            part_in = trial - (UW+1)'(dd_ff);
            q_in    = {q_ff[UW-2:0], 1'b1};
         end else begin
            part_in = trial;
            q_in    = {q_ff[UW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      part_ff <= part_in;
      q_ff    <= q_in;
      dd_ff   <= dd_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // sign and saturate
   always_comb begin
      qs = q_ff;
      if (neg_ff) begin
         if (qs > UW'(33'h080000000)) qo = 32'h80000000;
         else                         qo = 32'(-qs);
      end else begin
         if (qs > UW'(33'h07fffffff)) qo = 32'h7fffffff;
         else                         qo = qs[31:0];
      end
   end

   assign done = done_ff;
   assign quot = qo;
endmodule

[hdl/ttb_datapath.sv]
// ttb_datapath: vertex hold registers, deltas, products and result assembly
// depends on ttb_pkg, ttb_divider
module ttb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ttb_pkg::req_word_type req_word,
   input  ttb_pkg::ttb_cmd_type  cmd,
   output ttb_pkg::ttb_sts_type  sts,
   output ttb_pkg::rsp_word_type result
);
   import ttb_pkg::*;

   localparam int CW = ClampWidth;
   localparam int DW = DeltaWidth;

   req_word_type v0_ff, v1_ff, v2_ff;
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [ProdWidth-1:0] pa_ff [7];   // e1*dv2, e2*du1, du1*dv2
   logic signed [ProdWidth-1:0] pb_ff [7];   // e2*dv1, e1*du2, du2*dv1
   logic signed [SumWidth-1:0]  s_ff [7];    // t xyz, b xyz, det
   logic [31:0] out_ff [6];
   logic signed [NumWidth-1:0] num;
   logic [31:0] quot;
   logic div_done;

   function automatic logic signed [DW-1:0] dlt(
      input logic signed [CoordWidth-1:0] a, input logic signed [CoordWidth-1:0] b);
      return DW'(clamp_coord(a)) - DW'(clamp_coord(b));
   endfunction

   // vertex hold
   always_ff @(posedge clock) begin
      if (cmd.load_v0) v0_ff <= req_word;
      if (cmd.load_v1) v1_ff <= req_word;
      if (cmd.load_v2) v2_ff <= req_word;
   end

   // deltas, products, sums
   always_ff @(posedge clock) begin
      if (cmd.calc_delta) begin
         e1_ff[0] <= dlt(v1_ff.pos_x, v0_ff.pos_x);
         e1_ff[1] <= dlt(v1_ff.pos_y, v0_ff.pos_y);
         e1_ff[2] <= dlt(v1_ff.pos_z, v0_ff.pos_z);
         e2_ff[0] <= dlt(v2_ff.pos_x, v0_ff.pos_x);
         e2_ff[1] <= dlt(v2_ff.pos_y, v0_ff.pos_y);
         e2_ff[2] <= dlt(v2_ff.pos_z, v0_ff.pos_z);
         du1_ff   <= dlt(v1_ff.tex_u, v0_ff.tex_u);
         dv1_ff   <= dlt(v1_ff.tex_v, v0_ff.tex_v);
         du2_ff   <= dlt(v2_ff.tex_u, v0_ff.tex_u);
         dv2_ff   <= dlt(v2_ff.tex_v, v0_ff.tex_v);
      end
      if (cmd.calc_prod) begin
         for (int k = 0; k < 3; k++) begin
            pa_ff[k]   <= ProdWidth'(e1_ff[k] * dv2_ff);
            pb_ff[k]   <= ProdWidth'(e2_ff[k] * dv1_ff);
            pa_ff[3+k] <= ProdWidth'(e2_ff[k] * du1_ff);
            pb_ff[3+k] <= ProdWidth'(e1_ff[k] * du2_ff);
         end
         pa_ff[6] <= ProdWidth'(du1_ff * dv2_ff);
         pb_ff[6] <= ProdWidth'(du2_ff * dv1_ff);
      end
      if (cmd.calc_sum) begin
         for (int k = 0; k < 7; k++) begin
            s_ff[k] <= SumWidth'(pa_ff[k]) - SumWidth'(pb_ff[k]);
         end
      end
   end

   // shared divider over the six components
   assign num = NumWidth'(s_ff[cmd.div_sel]) <<< FracShift;

   ttb_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (s_ff[6]),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_store) out_ff[cmd.div_sel] <= quot;
   end

   assign sts.div_done = div_done;

   // zero determinant gives zero vectors
   always_comb begin
      if (s_ff[6] == '0) begin
         result = '0;
         result.degenerate = 1'b1;
      end else begin
         result.tangent_x   = out_ff[0];
         result.tangent_y   = out_ff[1];
         result.tangent_z   = out_ff[2];
         result.bitangent_x = out_ff[3];
         result.bitangent_y = out_ff[4];
         result.bitangent_z = out_ff[5];
         result.degenerate  = 1'b0;
      end
   end
endmodule

[hdl/ttb_ctrl.sv]
// ttb_ctrl: vertex slot tracking and sequencing of the triangle math
// depends on ttb_pkg
module ttb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ttb_pkg::ttb_sts_type sts,
   input  logic                 degen,
   output ttb_pkg::ttb_cmd_type cmd
);
   import ttb_pkg::*;

   typedef enum logic [2:0] {
      S_V0, S_V1, S_V2, S_DELTA, S_PROD, S_SUM, S_DIV, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] sel_ff, sel_in;
   logic       start_ff, start_in;
   logic       acc;

   assign req_ready = (state_ff == S_V0) || (state_ff == S_V1) || (state_ff == S_V2);
   assign rsp_valid = (state_ff == S_OUT);
   assign acc       = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      start_in = 1'b0;
      cmd      = '0;
      cmd.div_sel   = sel_ff;
      // a degenerate triangle never starts the divider
      cmd.div_start = start_ff && !degen;
      case (state_ff)
         S_V0: begin
            cmd.load_v0 = acc;
            if (acc) state_in = S_V1;
         end
         S_V1: begin
            cmd.load_v1 = acc;
            if (acc) state_in = S_V2;
         end
         S_V2: begin
            cmd.load_v2 = acc;
            if (acc) state_in = S_DELTA;
         end
         S_DELTA: begin
            cmd.calc_delta = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.calc_prod = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.calc_sum = 1'b1;
            state_in = S_DIV;
            sel_in   = '0;
            start_in = 1'b1;
         end
         S_DIV: begin
            if (degen) begin
               state_in = S_OUT;
            end else if (sts.div_done) begin
               cmd.div_store = 1'b1;
               if (sel_ff == 3'd5) begin
                  state_in = S_OUT;
               end else begin
                  sel_in   = sel_ff + 3'd1;
                  start_in = 1'b1;
               end
            end
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_V0;
         end
         default: state_in = S_V0;
      endcase
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      if (reset) begin
         state_ff <= S_V0;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end
endmodule

[hdl/triangle_tangent_bitangent_core.sv]
// Triangle tangent/bitangent core. Vertices come in triangle order; the first
// two are held and the third starts the math. The first two vertices of a
// triangle are taken one per cycle; the third blocks the input until the result
// word is taken. After the third vertex come the delta, product and sum steps,
// then six Q10.22 quotients one after another through a single restoring
// divider making one quotient bit per cycle. A zero determinant skips the
// divider and sets degenerate with zero vectors.
// depends on ttb_pkg, ttb_ctrl, ttb_datapath
module triangle_tangent_bitangent_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ttb_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ttb_pkg::rsp_word_type rsp_word
);
   import ttb_pkg::*;

   ttb_cmd_type cmd;
   ttb_sts_type sts;

   ttb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .degen     (rsp_word.degenerate),
      .cmd       (cmd)
   );

   ttb_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .result   (rsp_word)
   );
endmodule
